### hdl/a51_pkg.sv
// ----------------------------------------------------------------------------
// a51_pkg
// Shared widths, codes and sequencing constants of the A5/1 byte cipher.
// ----------------------------------------------------------------------------
package a51_pkg;

  localparam int KEY_W       = 64;
  localparam int FRAME_W     = 22;
  localparam int A_W         = 19;
  localparam int B_W         = 22;
  localparam int C_W         = 23;
  localparam int DATA_W      = 8;
  localparam int CFG_IDX_W   = 1;

  localparam int STORE_BYTES = 28;
  localparam int POS_W       = $clog2(STORE_BYTES);
  localparam int KEYSTREAM_LEN_DEF = 28;

  localparam int LOAD_STEPS  = KEY_W + FRAME_W;
  localparam int MIX_STEPS   = 100;
  localparam int OUT_STEPS   = 228;
  localparam int STORE_BITS  = STORE_BYTES * DATA_W;
  localparam int CNT_W       = 8;

  localparam logic OP_SETUP = 1'b0;
  localparam logic OP_CRYPT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SESSION_KEY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_NUMBER = 1'b1;

endpackage

### hdl/a51_if.sv
// ----------------------------------------------------------------------------
// a51 request channels
// Valid/ready channels for cipher requests and their results.
// ----------------------------------------------------------------------------
interface a51_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [a51_pkg::DATA_W-1:0]   data_in;
  logic                         first;

  modport source (output valid, output op, output data_in, output first, input ready);
  modport sink   (input valid, input op, input data_in, input first, output ready);
endinterface

interface a51_out_if;
  logic                         valid;
  logic                         ready;
  logic [a51_pkg::DATA_W-1:0]   data_out;
  logic                         not_ready;

  modport source (output valid, output data_out, output not_ready, input ready);
  modport sink   (input valid, input data_out, input not_ready, output ready);
endinterface

### hdl/a51_keystream_byte_cipher_core.sv
// ----------------------------------------------------------------------------
// a51_keystream_byte_cipher_core
// A5/1 keystream generator: key setup fills a 28-byte keystream RAM, data
// requests are XORed with the byte at the running position once a setup has run.
// ----------------------------------------------------------------------------
// Crypt request: result passes through stage 1 (keystream RAM read) and the
//   output register; one request per cycle sustained while the output is taken.
// Setup request: 86 load + 100 mix + 228 output LFSR steps, then the result
//   is posted through stage 1; no requests are taken during it.
// Reset (rst_n low, synchronous) clears LFSRs, position, key-ready and the
//   pipeline; keystream RAM contents stay undefined until the first setup.
module a51_keystream_byte_cipher_core #(
  parameter int KEYSTREAM_LEN = a51_pkg::KEYSTREAM_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [a51_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [a51_pkg::KEY_W-1:0]         cfg_wdata,
  a51_in_if.sink                            in_ch,
  a51_out_if.source                         out_ch
);

  localparam int POS_W = a51_pkg::POS_W;
  localparam int DW    = a51_pkg::DATA_W;
  localparam int LD_W  = a51_pkg::LOAD_STEPS;
  localparam logic [POS_W:0] KS_LEN = (POS_W+1)'(KEYSTREAM_LEN);
  localparam logic [a51_pkg::CNT_W-1:0] LOAD_LAST = a51_pkg::CNT_W'(a51_pkg::LOAD_STEPS - 1);
  localparam logic [a51_pkg::CNT_W-1:0] MIX_LAST  = a51_pkg::CNT_W'(a51_pkg::MIX_STEPS - 1);
  localparam logic [a51_pkg::CNT_W-1:0] OUT_LAST  = a51_pkg::CNT_W'(a51_pkg::OUT_STEPS - 1);
  localparam logic [a51_pkg::CNT_W-1:0] STORE_END = a51_pkg::CNT_W'(a51_pkg::STORE_BITS);
  localparam logic [a51_pkg::CNT_W-1:0] CNT_ONE   = a51_pkg::CNT_W'(1);

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_MIX, S_OUT, S_DONE} state_t;

  // configuration
  logic [a51_pkg::KEY_W-1:0]   key_r;
  logic [a51_pkg::FRAME_W-1:0] frame_r;

  // control and datapath registers
  state_t                      state_r, state_nxt;
  logic [a51_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [a51_pkg::A_W-1:0]     a_r, a_nxt;
  logic [a51_pkg::B_W-1:0]     b_r, b_nxt;
  logic [a51_pkg::C_W-1:0]     c_r, c_nxt;
  logic [LD_W-1:0]             ld_r, ld_nxt;
  logic [DW-1:0]               acc_r, acc_nxt;
  logic [POS_W-1:0]            pos_r, pos_nxt;
  logic                        kr_r, kr_nxt;
  logic                        s1_v_r, s1_v_nxt;
  logic                        s1_xor_r, s1_xor_nxt;
  logic                        s1_nr_r, s1_nr_nxt;
  logic [DW-1:0]               s1_data_r, s1_data_nxt;
  logic                        out_v_r, out_v_nxt;
  logic [DW-1:0]               out_data_r, out_data_nxt;
  logic                        out_nr_r, out_nr_nxt;

  // combinational
  logic             accept, s1_adv;
  logic             ram_we, ram_re;
  logic [POS_W-1:0] ram_raddr;
  logic [DW-1:0]    ram_q;
  logic [POS_W-1:0] pos_use;
  logic [POS_W:0]   pos_inc;
  logic             fa, fb, fc, maj, ld_bit, z_bit;
  logic [a51_pkg::A_W-1:0] a_step;
  logic [a51_pkg::B_W-1:0] b_step;
  logic [a51_pkg::C_W-1:0] c_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      frame_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        a51_pkg::REG_SESSION_KEY:  key_r   <= cfg_wdata;
        a51_pkg::REG_FRAME_NUMBER: frame_r <= cfg_wdata[a51_pkg::FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_adv = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = (state_r == S_IDLE) && (!s1_v_r || s1_adv);
  assign accept = in_ch.valid && in_ch.ready;

  // LFSR feedback and majority clocking
  assign fa  = a_r[13] ^ a_r[16] ^ a_r[17] ^ a_r[18];
  assign fb  = b_r[20] ^ b_r[21];
  assign fc  = c_r[7] ^ c_r[20] ^ c_r[21] ^ c_r[22];
  assign maj = (a_r[8] & b_r[10]) | (a_r[8] & c_r[10]) | (b_r[10] & c_r[10]);
  assign ld_bit = ld_r[0];
  assign a_step = (a_r[8]  == maj) ? {a_r[a51_pkg::A_W-2:0], fa} : a_r;
  assign b_step = (b_r[10] == maj) ? {b_r[a51_pkg::B_W-2:0], fb} : b_r;
  assign c_step = (c_r[10] == maj) ? {c_r[a51_pkg::C_W-2:0], fc} : c_r;
  assign z_bit  = a_step[a51_pkg::A_W-1] ^ b_step[a51_pkg::B_W-1] ^ c_step[a51_pkg::C_W-1];

  // position for a crypt request
  assign pos_use = (in_ch.first || ({1'b0, pos_r} >= KS_LEN)) ? '0 : pos_r;
  assign pos_inc = {1'b0, pos_use} + (POS_W+1)'(1);

  assign ram_we    = (state_r == S_OUT) && (cnt_r[2:0] == 3'b111) && (cnt_r < STORE_END);
  assign ram_re    = accept && (in_ch.op == a51_pkg::OP_CRYPT) && kr_r;
  assign ram_raddr = pos_use;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    c_nxt       = c_r;
    ld_nxt      = ld_r;
    acc_nxt     = acc_r;
    pos_nxt     = pos_r;
    kr_nxt      = kr_r;
    s1_v_nxt    = s1_adv ? 1'b0 : s1_v_r;
    s1_xor_nxt  = s1_xor_r;
    s1_nr_nxt   = s1_nr_r;
    s1_data_nxt = s1_data_r;
    out_v_nxt   = out_v_r;
    out_data_nxt = out_data_r;
    out_nr_nxt  = out_nr_r;

    // drain stage 1 into the output register
    if (s1_adv) begin
      out_v_nxt    = 1'b1;
      out_data_nxt = s1_xor_r ? (s1_data_r ^ ram_q) : s1_data_r;
      out_nr_nxt   = s1_nr_r;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.op == a51_pkg::OP_SETUP) begin
            state_nxt = S_LOAD;
            cnt_nxt   = '0;
            a_nxt     = '0;
            b_nxt     = '0;
            c_nxt     = '0;
            ld_nxt    = {frame_r, key_r};
          end else begin
            s1_v_nxt    = 1'b1;
            s1_xor_nxt  = kr_r;
            s1_nr_nxt   = !kr_r;
            s1_data_nxt = in_ch.data_in;
            if (kr_r) begin
              pos_nxt = (pos_inc >= KS_LEN) ? '0 : pos_inc[POS_W-1:0];
            end
          end
        end
      end
      S_LOAD: begin
        a_nxt  = {a_r[a51_pkg::A_W-2:0], fa ^ ld_bit};
        b_nxt  = {b_r[a51_pkg::B_W-2:0], fb ^ ld_bit};
        c_nxt  = {c_r[a51_pkg::C_W-2:0], fc ^ ld_bit};
        ld_nxt = ld_r >> 1;
        if (cnt_r == LOAD_LAST) begin
          state_nxt = S_MIX;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + CNT_ONE;
        end
      end
      S_MIX: begin
        a_nxt = a_step;
        b_nxt = b_step;
        c_nxt = c_step;
        if (cnt_r == MIX_LAST) begin
          state_nxt = S_OUT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + CNT_ONE;
        end
      end
      S_OUT: begin
        a_nxt   = a_step;
        b_nxt   = b_step;
        c_nxt   = c_step;
        acc_nxt = {acc_r[DW-2:0], z_bit};
        if (cnt_r == OUT_LAST) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + CNT_ONE;
        end
      end
      S_DONE: begin
        // wait for a free stage 1 slot, then post the setup result
        if (!s1_v_r || s1_adv) begin
          s1_v_nxt    = 1'b1;
          s1_xor_nxt  = 1'b0;
          s1_nr_nxt   = 1'b0;
          s1_data_nxt = '0;
          kr_nxt      = 1'b1;
          pos_nxt     = '0;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      a_r     <= '0;
      b_r     <= '0;
      c_r     <= '0;
      pos_r   <= '0;
      kr_r    <= 1'b0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      c_r     <= c_nxt;
      pos_r   <= pos_nxt;
      kr_r    <= kr_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
    ld_r       <= ld_nxt;
    acc_r      <= acc_nxt;
    s1_xor_r   <= s1_xor_nxt;
    s1_nr_r    <= s1_nr_nxt;
    s1_data_r  <= s1_data_nxt;
    out_data_r <= out_data_nxt;
    out_nr_r   <= out_nr_nxt;
  end

  a51_ram #(
    .WIDTH (DW),
    .DEPTH (a51_pkg::STORE_BYTES)
  ) u_ks_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[3 +: POS_W]),
    .wdata (acc_nxt),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  assign out_ch.valid     = out_v_r;
  assign out_ch.data_out  = out_data_r;
  assign out_ch.not_ready = out_nr_r;

  a_key_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    kr_r |=> kr_r)
    else $error("key ready dropped after setup");

  a_ram_write_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_OUT))
    else $error("keystream RAM written outside output phase");

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (state_r == S_IDLE))
    else $error("request accepted during key setup");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    kr_r |-> ({1'b0, pos_r} < KS_LEN))
    else $error("keystream position out of range");

  a_read_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> !ram_we)
    else $error("keystream read overlaps a write");

endmodule

### hdl/a51_ram.sv
// ----------------------------------------------------------------------------
// a51_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module a51_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 28
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // hold read data while no read is issued
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
